@@ rtl/core/tdp_pkg.sv @@
// tdp_pkg: shared types and constants for the trial division prime test
// no dependencies; compile first

package tdp_pkg;

    // fixed width of the candidate field on the input channel
    localparam int CAND_WIDTH = 32;

    // trial divisor constants
    localparam int DIV_TWO   = 2;
    localparam int DIV_THREE = 3;
    localparam int DIV_FIRST = 5;
    localparam int DIV_STEP  = 6;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD3,
        ST_DIV_D,
        ST_DIV_D2,
        ST_FINISH
    } t_state;

endpackage

@@ rtl/core/tdp_cand_if.sv @@
// tdp_cand_if: valid/ready channel carrying the candidate word
// depends on tdp_pkg

interface tdp_cand_if;
    import tdp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CAND_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

@@ rtl/core/tdp_result_if.sv @@
// tdp_result_if: valid/ready channel carrying the primality verdict word
// no dependencies

interface tdp_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

@@ rtl/core/tdp_div.sv @@
// tdp_div: serial restoring divider, one quotient bit per cycle
// gives quotient and remainder; no package dependency

module tdp_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dsr;

    logic [W:0]    partial;
    logic [W:0]    diff;
    logic          ge;

    // shift in next dividend bit, trial subtract
    assign partial = {r_rem, r_quo[W-1]};
    assign diff    = partial - {1'b0, r_dsr};
    assign ge      = (partial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : partial[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// trial_division_prime_test: top level, sequencer around one shared serial divider
// depends on tdp_pkg, tdp_cand_if, tdp_result_if, tdp_div

// Tests one candidate word for primality by trial division and returns one
// verdict word per candidate. Only the low NUM_WIDTH bits of the candidate are
// used (all 32 when NUM_WIDTH is 32 or more). Zero and one are reported not
// prime, two and three prime, even numbers are rejected at once, then one
// division by three, then divisor pairs d and d+2 for d = 5, 11, 17, ... while
// d does not exceed n/d; a zero remainder ends the test as composite, but the
// check d > n/d takes priority over it. All divisions run on a single restoring
// divider that yields one quotient bit per cycle. Even values and values below
// four are settled without any division. The input is not ready while a test
// runs. The verdict sits in an output register, so a new candidate is taken
// while the previous verdict still waits on the output channel.

module trial_division_prime_test #(
    parameter int NUM_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdp_cand_if.sink     i_cand,
    tdp_result_if.source o_res
);
    import tdp_pkg::*;

    localparam int W = NUM_WIDTH;

    // sequencer state and operands
    t_state       r_state, n_state;
    logic [W-1:0] r_n, n_n;
    logic [W-1:0] r_d, n_d;
    logic         r_verdict, n_verdict;

    // output register
    logic         r_out_valid;
    logic         r_out_prime;

    // divider hookup
    logic         div_start;
    logic [W-1:0] div_dividend;
    logic [W-1:0] div_divisor;
    logic         div_busy;
    logic         div_done;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;

    logic [W-1:0] cand_n;
    logic         in_accept;
    logic         out_free;
    logic         rem_zero;

    // keep the low bits of the candidate that the configured width allows
    generate
        if (W >= CAND_WIDTH) begin : g_cand_ext
            assign cand_n = W'(i_cand.candidate);
        end else begin : g_cand_trunc
            assign cand_n = i_cand.candidate[W-1:0];
        end
    endgenerate

    assign in_accept = i_cand.valid && i_cand.ready;
    assign out_free  = !r_out_valid || o_res.ready;
    assign rem_zero  = (div_rem == '0);

    tdp_div #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cand.valid) begin
                    // tiny and even values are settled without dividing
                    if (cand_n <= W'(DIV_THREE) || !cand_n[0]) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_MOD3;
                    end
                end
            end
            ST_MOD3: begin
                if (div_done) begin
                    n_state = rem_zero ? ST_FINISH : ST_DIV_D;
                end
            end
            ST_DIV_D: begin
                if (div_done) begin
                    // past the square root, or divisible by d
                    n_state = (r_d > div_quo || rem_zero) ? ST_FINISH : ST_DIV_D2;
                end
            end
            ST_DIV_D2: begin
                if (div_done) begin
                    n_state = rem_zero ? ST_FINISH : ST_DIV_D;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and operand updates
    always_comb begin
        i_cand.ready = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_n;
        div_divisor  = r_d;
        n_n          = r_n;
        n_d          = r_d;
        n_verdict    = r_verdict;
        unique case (r_state)
            ST_IDLE: begin
                i_cand.ready = 1'b1;
                n_n          = cand_n;
                // 2 and 3 prime, 0 and 1 not, other evens not
                n_verdict    = (cand_n == W'(DIV_TWO)) || (cand_n == W'(DIV_THREE));
                if (i_cand.valid && cand_n > W'(DIV_THREE) && cand_n[0]) begin
                    // r_n is only loaded at this edge, feed the new word directly
                    div_start    = 1'b1;
                    div_dividend = cand_n;
                    div_divisor  = W'(DIV_THREE);
                end
            end
            ST_MOD3: begin
                if (div_done) begin
                    n_verdict = 1'b0;
                    if (!rem_zero) begin
                        div_start   = 1'b1;
                        div_divisor = W'(DIV_FIRST);
                        n_d         = W'(DIV_FIRST);
                    end
                end
            end
            ST_DIV_D: begin
                if (div_done) begin
                    if (r_d > div_quo) begin
                        n_verdict = 1'b1;
                    end else if (rem_zero) begin
                        n_verdict = 1'b0;
                    end else begin
                        div_start   = 1'b1;
                        div_divisor = r_d + W'(DIV_TWO);
                    end
                end
            end
            ST_DIV_D2: begin
                if (div_done) begin
                    n_verdict = 1'b0;
                    if (!rem_zero) begin
                        div_start   = 1'b1;
                        div_divisor = r_d + W'(DIV_STEP);
                        n_d         = r_d + W'(DIV_STEP);
                    end
                end
            end
            ST_FINISH: begin
                div_start = 1'b0;
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_d       <= n_d;
        r_verdict <= n_verdict;
        if (r_state == ST_FINISH && out_free) begin
            r_out_prime <= r_verdict;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.is_prime = r_out_prime;

    // the divider is only started when idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // a zero candidate settles at once as not prime
    a_zero_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && cand_n == '0) |=> (r_state == ST_FINISH && !r_verdict))
        else $error("zero candidate not settled at once");

    // trial divisors are always odd
    a_odd_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_D || r_state == ST_DIV_D2) |-> r_d[0])
        else $error("even trial divisor");

endmodule
